/* rtl/assert_macros.svh */
// Assertion helpers for the neighbor table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds at each clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ntta_pkg.sv */
package ntta_pkg;

    localparam int unsigned NEIGHBORS_DEF = 32;
    localparam int unsigned DEFAULT_CAP   = 128;

    localparam logic [1:0] REQ_FRAME = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;

    localparam logic [1:0] EV_ADDED     = 2'd0;
    localparam logic [1:0] EV_REMOVED   = 2'd1;
    localparam logic [1:0] EV_UPDATED   = 2'd2;
    localparam logic [1:0] EV_REFRESHED = 2'd3;

    localparam logic [1:0] REG_MAX_ENTRIES = 2'd0;
    localparam logic [1:0] REG_FILTER_ADDR = 2'd1;
    localparam logic [1:0] REG_CAP_MASK    = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] now_time;
        logic [63:0] neighbor_key;
        logic [47:0] source_addr;
        logic [15:0] ttl_sec;
        logic        has_caps;
        logic [15:0] enabled_caps;
        logic [63:0] content_digest;
    } t_req;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [63:0] event_key;
        logic [5:0]  entry_count;
        logic        last;
    } t_evt;

    // Configuration register values seen by the engine
    typedef struct packed {
        logic [5:0]  max_entries;
        logic [47:0] filter_addr;
        logic [15:0] cap_mask;
    } t_cfg;

endpackage

/* rtl/ntta_if.sv */
interface ntta_req_if
    import ntta_pkg::*;
();
    logic valid;
    logic ready;
    t_req data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface ntta_evt_if
    import ntta_pkg::*;
();
    logic valid;
    logic ready;
    t_evt data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

/* rtl/ntta_cfg.sv */
module ntta_cfg
    import ntta_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);
    logic [5:0]  r_max;
    logic [47:0] r_filt;
    logic [15:0] r_mask;
    logic [1:0]  w_idx;
    logic        w_hit;

    assign w_idx  = paddr[4:3];
    assign w_hit  = (paddr[2:0] == 3'd0) && (paddr[4:3] != 2'd3);
    assign pready = 1'b1;

    // Write registers on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max  <= 6'd32;
            r_filt <= '0;
            r_mask <= 16'hFFFF;
        end else if (psel && penable && pwrite && w_hit) begin
            case (w_idx)
                REG_MAX_ENTRIES: r_max  <= pwdata[5:0];
                REG_FILTER_ADDR: r_filt <= pwdata[47:0];
                REG_CAP_MASK:    r_mask <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        if (w_hit) begin
            case (w_idx)
                REG_MAX_ENTRIES: prdata = {58'd0, r_max};
                REG_FILTER_ADDR: prdata = {16'd0, r_filt};
                REG_CAP_MASK:    prdata = {48'd0, r_mask};
                default:         prdata = '0;
            endcase
        end
    end

    assign o_cfg = '{max_entries: r_max, filter_addr: r_filt, cap_mask: r_mask};
endmodule

/* rtl/ntta_engine.sv */
module ntta_engine
    import ntta_pkg::*;
#(
    parameter int unsigned NEIGHBORS = NEIGHBORS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    ntta_req_if.sink    req,
    ntta_evt_if.source  evt
);
    localparam int unsigned SW = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
    localparam int unsigned CW = $clog2(NEIGHBORS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;

    localparam logic [1:0] P_KEY = 2'd0;
    localparam logic [1:0] P_EVI = 2'd1;

    // Slot memory: key, digest, expiry
    logic [63:0] m_key [NEIGHBORS];
    logic [63:0] m_dig [NEIGHBORS];
    logic [32:0] m_exp [NEIGHBORS];
    logic [NEIGHBORS-1:0] r_valid;

    logic [2:0]    r_st;
    logic [1:0]    r_ph;
    t_req          r_req;
    logic [CW-1:0] r_cnt;
    logic [SW:0]   r_addr;     // scan read address, one beyond the last slot ends
    logic          r_rdv;
    logic [SW-1:0] r_radr;
    logic [63:0]   r_rkey, r_rdig;
    logic [32:0]   r_rexp;
    logic          r_found;
    logic [SW-1:0] r_fslot;
    logic          r_best_v;
    logic [SW-1:0] r_best;
    logic [32:0]   r_bexp;
    logic [63:0]   r_bkey;
    logic          r_keep;
    logic          r_had;
    logic [CW-1:0] r_limit;
    logic          r_ov;
    t_evt          r_ev;
    t_evt          r_pend;     // event held back until its last flag is known
    logic          r_pv;

    logic [5:0]    cap6;
    logic [CW-1:0] cap;
    logic [32:0]   new_exp;
    logic          scan_end;
    logic [SW-1:0] free_slot;
    logic          rd_en;
    logic [SW-1:0] rd_a;
    logic          wr_en;
    logic [SW-1:0] wr_a;
    logic          wr_full;

    // Effective capacity, saturated to the table depth; zero also selects the full depth
    always_comb begin
        cap6 = i_cfg.max_entries;
        if (cap6 == 6'd0 || {26'd0, cap6} > NEIGHBORS)
            cap = CW'(NEIGHBORS);
        else
            cap = CW'(cap6);
    end

    assign new_exp  = {1'b0, r_req.now_time} + {17'd0, r_req.ttl_sec};
    assign req.ready = (r_st == S_IDLE);
    assign evt.valid = r_ov;
    assign evt.data  = r_ev;
    assign scan_end  = (r_addr == (SW+1)'(NEIGHBORS));
    assign rd_en     = (r_st == S_SCAN) && !scan_end;
    assign rd_a      = r_addr[SW-1:0];

    // Lowest free slot, priority encode over valid bits
    always_comb begin
        free_slot = '0;
        for (int i = NEIGHBORS - 1; i >= 0; i--)
            if (!r_valid[i]) free_slot = SW'(i);
    end

    // Registered memory read
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rkey <= m_key[rd_a];
            r_rdig <= m_dig[rd_a];
            r_rexp <= m_exp[rd_a];
        end
    end

    // Memory write: full entry on insert, expiry alone on refresh
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            m_exp[wr_a] <= new_exp;
            if (wr_full) begin
                m_key[wr_a] <= r_req.neighbor_key;
                m_dig[wr_a] <= r_req.content_digest;
            end
        end
    end

    // Control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_valid <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_rdv   <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            if (evt.valid && evt.ready) r_ov <= 1'b0;
            r_rdv  <= rd_en;
            r_radr <= rd_a;
            case (r_st)
                S_IDLE: begin
                    if (req.valid) begin
                        r_req  <= req.data;
                        r_addr <= '0;
                        r_found <= 1'b0;
                        r_best_v <= 1'b0;
                        r_had  <= 1'b0;
                        r_pv   <= 1'b0;
                        r_keep <= !(req.data.ttl_sec == 16'd0
                            || (i_cfg.filter_addr != 48'd0
                                && i_cfg.filter_addr == req.data.source_addr)
                            || (req.data.has_caps
                                && (req.data.enabled_caps & i_cfg.cap_mask) == 16'd0));
                        case (req.data.req_type)
                            REQ_FRAME: begin
                                r_ph <= P_KEY;
                                r_st <= S_SCAN;
                                r_limit <= (cap > CW'(1)) ? cap - CW'(1) : '0;
                            end
                            REQ_TICK: begin
                                r_ph <= P_EVI;
                                r_st <= S_SCAN;
                                r_limit <= cap;
                            end
                            REQ_FLUSH: begin
                                r_valid <= '0;
                                r_cnt   <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (!scan_end) r_addr <= r_addr + 1'b1;
                    // Compare the entry read last cycle
                    if (r_rdv && r_valid[r_radr]) begin
                        if (r_ph == P_KEY) begin
                            if (!r_found && r_rkey == r_req.neighbor_key) begin
                                r_found <= 1'b1;
                                r_fslot <= r_radr;
                                r_bkey  <= r_rdig;
                            end
                        end else if (!r_best_v || r_rexp < r_bexp) begin
                            r_best_v <= 1'b1;
                            r_best   <= r_radr;
                            r_bexp   <= r_rexp;
                            r_bkey   <= r_rkey;
                        end
                    end
                    if (scan_end && !r_rdv) r_st <= S_DEC;
                end
                S_DEC: begin
                    // Decide only once the event register is free
                    if (!r_ov) begin
                        r_st <= S_IDLE;
                        if (r_ph == P_KEY) begin
                            // Key lookup outcome; r_bkey holds the found digest
                            if (r_found && !r_keep) begin
                                r_valid[r_fslot] <= 1'b0;
                                r_cnt <= r_cnt - 1'b1;
                                r_ev  <= '{EV_REMOVED, r_req.neighbor_key,
                                           6'(r_cnt - 1'b1), 1'b1};
                                r_ov  <= 1'b1;
                                r_st  <= S_WAIT;
                            end else if (r_found && r_bkey == r_req.content_digest) begin
                                r_ev  <= '{EV_REFRESHED, r_req.neighbor_key, 6'(r_cnt),
                                           1'b1};
                                r_ov  <= 1'b1;
                                r_st  <= S_WAIT;
                            end else if (r_found || r_keep) begin
                                if (r_found) begin
                                    r_valid[r_fslot] <= 1'b0;
                                    r_cnt <= r_cnt - 1'b1;
                                    r_had <= 1'b1;
                                end
                                r_ph <= P_EVI;
                                r_addr <= '0;
                                r_best_v <= 1'b0;
                                r_st <= S_SCAN;
                            end
                        end else begin
                            // Eviction step on the earliest-expiring entry, else insert a frame or end a tick
                            if (r_best_v && (r_cnt > r_limit
                                    || r_bexp <= {1'b0, r_req.now_time})) begin
                                r_valid[r_best] <= 1'b0;
                                r_cnt <= r_cnt - 1'b1;
                                r_pend <= '{EV_REMOVED, r_bkey, 6'(r_cnt - 1'b1), 1'b0};
                                r_pv <= 1'b1;
                                // Present the previous removal, more follow it
                                if (r_pv) begin
                                    r_ev <= r_pend;
                                    r_ov <= 1'b1;
                                end
                                r_addr <= '0;
                                r_best_v <= 1'b0;
                                r_st <= S_SCAN;
                            end else if (r_req.req_type == REQ_FRAME) begin
                                r_valid[free_slot] <= 1'b1;
                                r_cnt <= r_cnt + 1'b1;
                                if (r_pv) begin
                                    r_ev   <= r_pend;
                                    r_ov   <= 1'b1;
                                    r_pend <= '{(r_had ? EV_UPDATED : EV_ADDED),
                                                r_req.neighbor_key, 6'(r_cnt + 1'b1),
                                                1'b1};
                                    r_st   <= S_EMIT;
                                end else begin
                                    r_ev <= '{(r_had ? EV_UPDATED : EV_ADDED),
                                              r_req.neighbor_key, 6'(r_cnt + 1'b1),
                                              1'b1};
                                    r_ov <= 1'b1;
                                    r_st <= S_WAIT;
                                end
                            end else if (r_pv) begin
                                // Tick ends: the held removal is the last event
                                r_ev <= '{r_pend.event_res, r_pend.event_key,
                                          r_pend.entry_count, 1'b1};
                                r_ov <= 1'b1;
                                r_pv <= 1'b0;
                                r_st <= S_WAIT;
                            end
                        end
                    end
                end
                S_EMIT: begin
                    // Present the held insert event once the register empties
                    if (!r_ov) begin
                        r_ev <= r_pend;
                        r_ov <= 1'b1;
                        r_pv <= 1'b0;
                        r_st <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (!r_ov || (evt.valid && evt.ready)) r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign wr_en   = (r_st == S_DEC) && !r_ov && (r_ph == P_KEY ?
                     (r_found && r_keep && r_bkey == r_req.content_digest) :
                     (!(r_best_v && (r_cnt > r_limit
                       || r_bexp <= {1'b0, r_req.now_time}))
                      && r_req.req_type == REQ_FRAME));
    assign wr_full = (r_ph == P_EVI);
    assign wr_a    = (r_ph == P_KEY) ? r_fslot : free_slot;
endmodule

/* rtl/neighbor_table_with_ttl_aging_unit.sv */
// Neighbor table with TTL aging.
// Requests enter on req_ch (valid/ready); each carries a frame, tick or flush.
// Events leave on evt_ch (valid/ready), one per table change; the final event
// of a request has last set. Flush, the unused code, dropped unknown frames
// and ticks that remove nothing yield no event.
// Configuration must be written over the APB port only while the unit is idle;
// the block does not enforce it. Every pass over the table reads one slot per
// cycle from the slot memory and ends in a decision step. A frame that inserts
// costs one key pass plus one pass per eviction and one for the insert; a tick
// costs one pass per removed entry plus one. Flush is done in the idle state.
// One request is handled at a time; ready is low while it is in work.
// A removal is held back one pass so that its last flag is known. The event
// register holds a result until taken; when the receiver stalls, the next
// pass runs but its decision waits for the register to empty.
// Reset clears all valid bits, the count and the event flags; it sets the
// configuration registers to their defaults.
module neighbor_table_with_ttl_aging_unit
    import ntta_pkg::*;
#(
    parameter int unsigned NEIGHBORS = NEIGHBORS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ntta_req_if.sink    req_ch,
    ntta_evt_if.source  evt_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
`include "assert_macros.svh"
    t_cfg cfg;

    ntta_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(cfg)
    );

    ntta_engine #(.NEIGHBORS(NEIGHBORS)) u_eng (
        .i_clk, .i_rst_n, .i_cfg(cfg), .req(req_ch), .evt(evt_ch)
    );

    `CHK_IMPL(a_cnt_max, i_clk, i_rst_n, evt_ch.valid,
        evt_ch.data.entry_count <= 6'(NEIGHBORS), "entry count beyond table")
    `CHK_NEXT(a_hold, i_clk, i_rst_n, evt_ch.valid && !evt_ch.ready,
        evt_ch.valid, "event dropped while stalled")
    `CHK_NEXT(a_stable, i_clk, i_rst_n, evt_ch.valid && !evt_ch.ready,
        $stable(evt_ch.data), "event changed while stalled")
endmodule
